FILE: rtl/core/p1305_pkg.sv
// p1305_pkg: word types, register indexes and limb widths for the poly1305 engine
// no dependencies; imported by poly1305_mac_engine
package p1305_pkg;

    // limb arithmetic in radix 2^26
    localparam int LIMB_W   = 26;
    localparam int N_LIMBS  = 5;
    localparam int ACC_W    = 27;   // stored accumulator limb, limb 1 may carry one bit
    localparam int HIN_W    = 28;   // accumulator limb plus message limb
    localparam int COEF_W   = 29;   // key limb times five
    localparam int PROD_W   = HIN_W + COEF_W;
    localparam int DACC_W   = PROD_W + 5;
    localparam int CARRY_W  = DACC_W - LIMB_W;
    localparam int KEY_W    = 64;
    localparam int CFG_IDX_W = 2;

    // clamp masks on the key limbs
    localparam logic [LIMB_W-1:0] R1_CLAMP = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] R2_CLAMP = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] R3_CLAMP = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] R4_CLAMP = 26'h00fffff;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_R_LOW  = 2'd0,
        CFG_R_HIGH = 2'd1,
        CFG_S_LOW  = 2'd2,
        CFG_S_HIGH = 2'd3
    } t_cfg_idx;

    // input word: one message block
    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  byte_count;
        logic        last_block;
    } t_in_word;

    // output word: the tag
    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } t_out_word;

endpackage

FILE: rtl/core/poly1305_mac_engine.sv
// Poly1305 engine: a message block of up to 16 bytes per word in, a 128-bit tag out
// Steps: a block with bytes issues 25 limb products on one 28x29 multiplier, drains the
// last product and folds the top carry; a last word then runs the final reduction
// before the tag. A word of zero bytes skips the multiply; no new word is taken until idle;
// the tag step also waits while the previous tag is held by the output stall.
// Reset (synchronous, active low) clears keys, accumulator, sequencer and output valid.
module poly1305_mac_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [p1305_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [p1305_pkg::KEY_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  p1305_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output p1305_pkg::t_out_word          o_out_word
);
    import p1305_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_FIX    = 6'b000100,
        S_FCARRY = 6'b001000,
        S_FSEL   = 6'b010000,
        S_TAG    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [KEY_W-1:0] r_key_r_low, r_key_r_high, r_key_s_low, r_key_s_high;
    logic [ACC_W-1:0] r_acc_limb [N_LIMBS];
    logic [HIN_W-1:0] r_hin [N_LIMBS];
    logic             r_last;
    logic [2:0]       r_k, r_j;
    logic             r_issuing;
    logic [PROD_W-1:0] r_prod;
    logic             r_prod_vld, r_prod_first, r_prod_last;
    logic [2:0]       r_prod_k;
    logic [DACC_W-1:0] r_dacc;
    logic [CARRY_W-1:0] r_carry;
    logic [HIN_W-1:0] r_fh [N_LIMBS];
    logic [63:0]      r_lo, r_hi;
    logic             r_out_vld;
    t_out_word        r_out_word;

    logic             in_acc, out_free, issue_end, mul_done;
    logic [4:0]       n_sat;
    logic [127:0]     blk;
    logic [128:0]     msg;
    logic [LIMB_W-1:0] r_limb [N_LIMBS];
    logic [COEF_W-1:0] s_limb [N_LIMBS];
    logic [COEF_W-1:0] coef;
    logic [2:0]       coef_idx;
    logic [DACC_W-1:0] dsum;
    logic [39:0]      fix_sum;
    logic [HIN_W-1:0] fc [N_LIMBS];
    logic [HIN_W-1:0] g [N_LIMBS];
    logic [HIN_W-1:0] hs [N_LIMBS];
    logic             sel;
    logic [127:0]     tag_sum;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;
    assign blk      = {i_in_word.block_high, i_in_word.block_low};

    // byte count saturation, masking of unused bytes and the pad bit
    always_comb begin
        n_sat = (i_in_word.byte_count > 5'd16) ? 5'd16 : i_in_word.byte_count;
        msg = '0;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < n_sat) begin
                msg[8*b +: 8] = blk[8*b +: 8];
            end
        end
        for (int b = 0; b <= 16; b++) begin
            if (5'(b) == n_sat) begin
                msg[8*b] = 1'b1;
            end
        end
    end

    // clamped key limbs and their multiples of five
    always_comb begin
        r_limb[0] = r_key_r_low[25:0];
        r_limb[1] = r_key_r_low[51:26] & R1_CLAMP;
        r_limb[2] = {r_key_r_high[13:0], r_key_r_low[63:52]} & R2_CLAMP;
        r_limb[3] = r_key_r_high[39:14] & R3_CLAMP;
        r_limb[4] = {2'b00, r_key_r_high[63:40]} & R4_CLAMP;
        for (int i = 0; i < N_LIMBS; i++) begin
            s_limb[i] = {1'b0, r_limb[i], 2'b00} + {3'b000, r_limb[i]};
        end
    end

    // coefficient for product h[j] * r[k-j], wrapping to 5*r above the diagonal
    always_comb begin
        if (r_j <= r_k) begin
            coef_idx = r_k - r_j;
            coef = {3'b000, r_limb[coef_idx]};
        end else begin
            coef_idx = 3'(r_k + 3'd5 - r_j);
            coef = s_limb[coef_idx];
        end
    end

    assign issue_end = (r_k == 3'(N_LIMBS - 1)) && (r_j == 3'(N_LIMBS - 1));
    assign dsum = (r_prod_first ? {{(DACC_W-CARRY_W){1'b0}}, r_carry} : r_dacc)
                  + {{(DACC_W-PROD_W){1'b0}}, r_prod};
    assign mul_done = r_prod_vld && r_prod_last && (r_prod_k == 3'(N_LIMBS - 1));

    // fold the top carry back into limb 0 times five
    assign fix_sum = {14'b0, r_acc_limb[0][LIMB_W-1:0]}
                     + {2'b00, r_carry, 2'b00} + {4'b0000, r_carry};

    // final carry chain on the accumulator
    always_comb begin
        logic [HIN_W-1:0] c;
        fc[1] = {1'b0, r_acc_limb[1]};
        c     = HIN_W'(fc[1] >> LIMB_W);
        fc[1] = fc[1] & HIN_W'(2**LIMB_W - 1);
        fc[2] = {1'b0, r_acc_limb[2]} + c;
        c     = HIN_W'(fc[2] >> LIMB_W);
        fc[2] = fc[2] & HIN_W'(2**LIMB_W - 1);
        fc[3] = {1'b0, r_acc_limb[3]} + c;
        c     = HIN_W'(fc[3] >> LIMB_W);
        fc[3] = fc[3] & HIN_W'(2**LIMB_W - 1);
        fc[4] = {1'b0, r_acc_limb[4]} + c;
        c     = HIN_W'(fc[4] >> LIMB_W);
        fc[4] = fc[4] & HIN_W'(2**LIMB_W - 1);
        fc[0] = {1'b0, r_acc_limb[0]} + (c << 2) + c;
        c     = HIN_W'(fc[0] >> LIMB_W);
        fc[0] = fc[0] & HIN_W'(2**LIMB_W - 1);
        fc[1] = fc[1] + c;
    end

    // trial subtraction of p and selection
    always_comb begin
        logic [HIN_W-1:0] c;
        g[0] = r_fh[0] + HIN_W'(5);
        c    = HIN_W'(g[0] >> LIMB_W);
        g[0] = g[0] & HIN_W'(2**LIMB_W - 1);
        for (int i = 1; i < N_LIMBS; i++) begin
            g[i] = r_fh[i] + c;
            c    = HIN_W'(g[i] >> LIMB_W);
            if (i < N_LIMBS - 1) begin
                g[i] = g[i] & HIN_W'(2**LIMB_W - 1);
            end
        end
        sel = (g[4] >= HIN_W'(2**LIMB_W));
        for (int i = 0; i < N_LIMBS; i++) begin
            hs[i] = sel ? (g[i] & HIN_W'(2**LIMB_W - 1)) : r_fh[i];
        end
    end

    assign tag_sum = {r_hi, r_lo} + {r_key_s_high, r_key_s_low};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (n_sat != 5'd0) begin
                        n_state = S_MUL;
                    end else if (i_in_word.last_block) begin
                        n_state = S_FCARRY;
                    end
                end
            end
            S_MUL:    if (mul_done) n_state = S_FIX;
            S_FIX:    n_state = r_last ? S_FCARRY : S_IDLE;
            S_FCARRY: n_state = S_FSEL;
            S_FSEL:   n_state = S_TAG;
            S_TAG:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issuing  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_key_r_low  <= '0;
            r_key_r_high <= '0;
            r_key_s_low  <= '0;
            r_key_s_high <= '0;
            for (int i = 0; i < N_LIMBS; i++) begin
                r_acc_limb[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_prod_vld <= (r_state == S_MUL) && r_issuing;
            if (r_state == S_IDLE && in_acc && n_sat != 5'd0) begin
                r_issuing <= 1'b1;
            end else if (r_state == S_MUL && r_issuing && issue_end) begin
                r_issuing <= 1'b0;
            end
            // output valid: set by a new tag, cleared when the tag is taken
            if (r_state == S_TAG && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            // key registers
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_R_LOW:  r_key_r_low  <= i_cfg_data;
                    CFG_R_HIGH: r_key_r_high <= i_cfg_data;
                    CFG_S_LOW:  r_key_s_low  <= i_cfg_data;
                    CFG_S_HIGH: r_key_s_high <= i_cfg_data;
                    default:    ;
                endcase
            end
            // accumulator limbs: product sums, carry fold, clear after the tag
            if (r_prod_vld && r_prod_last) begin
                r_acc_limb[r_prod_k] <= {1'b0, dsum[LIMB_W-1:0]};
            end
            if (r_state == S_FIX) begin
                r_acc_limb[0] <= {1'b0, fix_sum[LIMB_W-1:0]};
                r_acc_limb[1] <= ACC_W'(r_acc_limb[1] + {13'b0, fix_sum[39:LIMB_W]});
            end
            if (r_state == S_TAG && out_free) begin
                for (int i = 0; i < N_LIMBS; i++) begin
                    r_acc_limb[i] <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // load the padded block added to the accumulator
        if (r_state == S_IDLE && in_acc) begin
            r_last  <= i_in_word.last_block;
            r_k     <= '0;
            r_j     <= '0;
            r_carry <= '0;
            r_hin[0] <= {1'b0, r_acc_limb[0]} + {2'b00, msg[25:0]};
            r_hin[1] <= {1'b0, r_acc_limb[1]} + {2'b00, msg[51:26]};
            r_hin[2] <= {1'b0, r_acc_limb[2]} + {2'b00, msg[77:52]};
            r_hin[3] <= {1'b0, r_acc_limb[3]} + {2'b00, msg[103:78]};
            r_hin[4] <= {1'b0, r_acc_limb[4]} + {3'b000, msg[128:104]};
        end
        // issue one limb product per cycle
        if (r_state == S_MUL && r_issuing) begin
            r_prod       <= PROD_W'(r_hin[r_j] * coef);
            r_prod_first <= (r_j == 3'd0);
            r_prod_last  <= (r_j == 3'(N_LIMBS - 1));
            r_prod_k     <= r_k;
            if (r_j == 3'(N_LIMBS - 1)) begin
                r_j <= '0;
                r_k <= r_k + 3'd1;
            end else begin
                r_j <= r_j + 3'd1;
            end
        end
        // accumulate products, carry into the next column
        if (r_prod_vld) begin
            if (r_prod_last) begin
                r_carry <= dsum[DACC_W-1:LIMB_W];
            end else begin
                r_dacc <= dsum;
            end
        end
        if (r_state == S_FCARRY) begin
            for (int i = 0; i < N_LIMBS; i++) begin
                r_fh[i] <= fc[i];
            end
        end
        // pack limbs into two 64-bit halves
        if (r_state == S_FSEL) begin
            r_lo <= {36'b0, hs[0]} | ({36'b0, hs[1]} << 26) | ({36'b0, hs[2]} << 52);
            r_hi <= ({36'b0, hs[2]} >> 12) | ({36'b0, hs[3]} << 14)
                    | ({36'b0, hs[4]} << 40);
        end
        if (r_state == S_TAG && out_free) begin
            r_out_word.tag_low  <= tag_sum[63:0];
            r_out_word.tag_high <= tag_sum[127:64];
        end
    end

`ifndef SYNTHESIS
    // products only flow while multiplying
    a_prod_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> (r_state == S_MUL))
        else $error("product pending outside multiply phase");

    // limb counters stay within five limbs while issuing
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_issuing) |-> (r_k < 3'd5 && r_j < 3'd5))
        else $error("limb counter out of range");

    // a tag write shows on the output next cycle
    a_tag_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG && out_free) |=> o_out_valid)
        else $error("tag not presented");

    // accumulator limbs 0, 2 and 4 are empty after the tag
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG && out_free) |=>
            (r_acc_limb[0] == '0 && r_acc_limb[2] == '0 && r_acc_limb[4] == '0))
        else $error("accumulator not cleared after tag");
`endif

endmodule
